/* design/aehn_pkg.sv */
// ----------------------------------------------------------------------------
// aehn_pkg
// Shared widths, constants, codes and handshake structs for the audio
// envelope history normaliser.
// ----------------------------------------------------------------------------
`default_nettype none

package aehn_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 12;
    localparam int HEIGHT_W    = 8;
    localparam int WIDTH_CFG_W = 7;
    localparam int COL_W       = 6;
    localparam int TOP_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    localparam int DEFAULT_HISTORY_DEPTH = 64;

    localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX   = 12'hFFF;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 8'd128;
    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET  = 7'd64;

    // Peak smoothing: (19*s + max + 10) / 20
    localparam int SMOOTH_KEEP = 19;
    localparam int SMOOTH_BIAS = 10;
    // Divide by 20 as a shift by 2, then a reciprocal multiply for the 5
    localparam int SMOOTH_SUM_W     = 17;
    localparam int SMOOTH_PRE_SHIFT = 2;
    localparam int SMOOTH_RECIP     = 52429;
    localparam int SMOOTH_SHIFT     = 18;
    localparam int SMOOTH_PROD_W    = 31;

    // Iterative divider widths
    localparam int DIV_NW = 22;
    localparam int DIV_DW = 13;
    localparam int DIV_CW = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_HEIGHT = 1'b0,
        CFG_DISPLAY_WIDTH  = 1'b1
    } cfg_idx_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* design/aehn_divider.sv */
// ----------------------------------------------------------------------------
// aehn_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aehn_divider
    import aehn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW+1:0] diff;

    // Shift in the next dividend bit and trial subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[DIV_DW+1])
                begin
                    rem_reg <= diff[DIV_DW-1:0];
                    quo_reg <= {quo_reg[DIV_NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DIV_DW-1:0];
                    quo_reg <= {quo_reg[DIV_NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* design/aehn_hist_mem.sv */
// ----------------------------------------------------------------------------
// aehn_hist_mem
// Amplitude history store: one write and one registered read per cycle,
// with a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aehn_hist_mem
    import aehn_pkg::*;
#(
    parameter int DEPTH = DEFAULT_HISTORY_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic [SAMPLE_W-1:0] wdata,
    input  wire logic [AW-1:0]       raddr,
    output logic [SAMPLE_W-1:0]      rdata
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic [SAMPLE_W-1:0] rd_reg;
    logic                rd_vld_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Mark written entries; reset returns the whole history to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

`default_nettype wire

/* design/audio_envelope_history_normalizer.sv */
// Sample requests: accepted one per cycle while idle, no result.
// Close requests: the history shift (skipped for one column), the write of the new
// amplitude and the peak smoothing run in turn; each column is then read, scaled
// and divided by the bit-serial divider, which is skipped when the frame is flat;
// a stalled output holds the column step. No request is taken during a frame.
// Reset: history reads as zeros, window and smoothed peak at reset values.
// ----------------------------------------------------------------------------
// audio_envelope_history_normalizer
// Tracks the window min/max of microphone samples and, on a close request,
// shifts the amplitude into a history and emits normalised centred columns.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_envelope_history_normalizer
    import aehn_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] sample
    input  wire logic                  s_axis_tuser,  // [0] func
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [5:0] column, [13:6] height,
                                                      // [20:14] top_offset
    output logic                       m_axis_tlast   // last
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int WW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT_WR,
        ST_PUT,
        ST_SMOOTH,
        ST_SMOOTH_WAIT,
        ST_COL_RD,
        ST_COL_MUL,
        ST_COL_DIV,
        ST_COL_WAIT,
        ST_COL_OUT
    } state_t;

    state_t                  state_reg;
    logic [HEIGHT_W-1:0]     height_cfg_reg;
    logic [WIDTH_CFG_W-1:0]  width_cfg_reg;
    logic [SAMPLE_W-1:0]     win_hi_reg;
    logic [SAMPLE_W-1:0]     win_lo_reg;
    logic [SAMPLE_W-1:0]     smooth_reg;
    logic [SMOOTH_SUM_W-1:0] smooth_sum_reg;
    logic [SAMPLE_W-1:0]     amp_reg;
    logic [SAMPLE_W-1:0]     hist_lo_reg;
    logic [SAMPLE_W-1:0]     hist_hi_reg;
    logic [WW-1:0]           w_reg;
    logic [AW-1:0]           idx_reg;
    logic [HEIGHT_W+SAMPLE_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0]     span_reg;
    logic [HEIGHT_W-1:0]     bar_h_reg;
    logic                    out_valid_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic [HEIGHT_W-1:0]     out_height_reg;
    logic [TOP_W-1:0]        out_top_reg;
    logic                    out_last_reg;

    logic                    in_req;
    logic                    func;
    logic [SAMPLE_W-1:0]     sample;
    logic [SAMPLE_W-1:0]     amp_next;
    logic [WW-1:0]           w_next;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [SAMPLE_W-1:0]     mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [SAMPLE_W-1:0]     mem_rdata;
    logic [AW-1:0]           last_addr;
    logic                    out_free;
    logic                    out_load;
    logic [HEIGHT_W-1:0]     bar;
    logic [TOP_W-1:0]        top_next;
    logic [SMOOTH_PROD_W-1:0] smooth_prod;
    logic [SAMPLE_W:0]       smooth_quo;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign func          = s_axis_tuser;
    assign sample        = s_axis_tdata[SAMPLE_W-1:0];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_COL_OUT) && out_free;
    assign last_addr     = AW'(w_reg - WW'(1));

    // Peak-to-peak of the closing window; empty window gives zero
    assign amp_next = (win_hi_reg >= win_lo_reg) ? (win_hi_reg - win_lo_reg) : '0;

    // Clamp the column count into 1..HISTORY_DEPTH
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_next = WW'(1);
        end
        else if (width_cfg_reg > WIDTH_CFG_W'(HISTORY_DEPTH))
        begin
            w_next = WW'(HISTORY_DEPTH);
        end
        else
        begin
            w_next = WW'(width_cfg_reg);
        end
    end

    // History access: shift walk, amplitude write, column reads
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_raddr = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = AW'(1);
            end
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_raddr = AW'({1'b0, idx_reg} + (AW+1)'(2));
            end
            ST_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = last_addr;
                mem_wdata = amp_reg;
            end
            default:
            begin
                mem_raddr = idx_reg;
            end
        endcase
    end

    aehn_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Divide the smoothing sum by twenty: quarter it, then multiply by 1/5
    always_comb
    begin
        smooth_prod = SMOOTH_PROD_W'(smooth_sum_reg >> SMOOTH_PRE_SHIFT)
                    * SMOOTH_PROD_W'(SMOOTH_RECIP);
        smooth_quo  = smooth_prod[SMOOTH_SHIFT +: SAMPLE_W+1];
    end

    // Divider requests: one per column whose smoothed peak exceeds the history minimum
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_NW'({prod_reg, 1'b0}) + DIV_NW'(span_reg);
        div_req.divisor  = DIV_DW'({span_reg, 1'b0});
        case (state_reg)
            ST_COL_DIV:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    aehn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Centre the bar: offset of its top row
    always_comb
    begin
        bar      = (bar_h_reg == '0) ? HEIGHT_W'(1) : bar_h_reg;
        top_next = (height_cfg_reg >= bar) ? TOP_W'((height_cfg_reg - bar) >> 1) : '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_cfg_reg <= HEIGHT_RESET;
            width_cfg_reg  <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DISPLAY_HEIGHT: height_cfg_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_DISPLAY_WIDTH:  width_cfg_reg  <= cfg_wdata[WIDTH_CFG_W-1:0];
                default:            height_cfg_reg <= height_cfg_reg;
            endcase
        end
    end

    // Frame sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_hi_reg     <= '0;
            win_lo_reg     <= SAMPLE_MAX;
            smooth_reg     <= SAMPLE_MAX;
            smooth_sum_reg <= '0;
            amp_reg        <= '0;
            hist_lo_reg    <= '0;
            hist_hi_reg    <= '0;
            w_reg          <= WW'(1);
            idx_reg        <= '0;
            prod_reg       <= '0;
            span_reg       <= '0;
            bar_h_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_col_reg    <= '0;
            out_height_reg <= '0;
            out_top_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Load a new column, or drop the result once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_req && !func)
                    begin
                        if (sample > win_hi_reg)
                        begin
                            win_hi_reg <= sample;
                        end
                        if (sample < win_lo_reg)
                        begin
                            win_lo_reg <= sample;
                        end
                    end
                    else if (in_req)
                    begin
                        amp_reg     <= amp_next;
                        hist_lo_reg <= amp_next;
                        hist_hi_reg <= amp_next;
                        win_hi_reg  <= '0;
                        win_lo_reg  <= SAMPLE_MAX;
                        w_reg       <= w_next;
                        idx_reg     <= '0;
                        state_reg   <= (w_next == WW'(1)) ? ST_PUT : ST_SHIFT_WR;
                    end
                end
                ST_SHIFT_WR:
                begin
                    if (mem_rdata < hist_lo_reg)
                    begin
                        hist_lo_reg <= mem_rdata;
                    end
                    if (mem_rdata > hist_hi_reg)
                    begin
                        hist_hi_reg <= mem_rdata;
                    end
                    if (WW'(idx_reg) + WW'(2) == w_reg)
                    begin
                        state_reg <= ST_PUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                ST_PUT:
                begin
                    state_reg <= ST_SMOOTH;
                end
                ST_SMOOTH:
                begin
                    smooth_sum_reg <= SMOOTH_SUM_W'(smooth_reg) * SMOOTH_SUM_W'(SMOOTH_KEEP)
                                    + SMOOTH_SUM_W'(hist_hi_reg)
                                    + SMOOTH_SUM_W'(SMOOTH_BIAS);
                    state_reg      <= ST_SMOOTH_WAIT;
                end
                ST_SMOOTH_WAIT:
                begin
                    if (smooth_quo[SAMPLE_W])
                    begin
                        smooth_reg <= SAMPLE_MAX;
                    end
                    else
                    begin
                        smooth_reg <= smooth_quo[SAMPLE_W-1:0];
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_COL_RD;
                end
                ST_COL_RD:
                begin
                    state_reg <= ST_COL_MUL;
                end
                ST_COL_MUL:
                begin
                    prod_reg <= (HEIGHT_W+SAMPLE_W)'(height_cfg_reg)
                              * (HEIGHT_W+SAMPLE_W)'(mem_rdata - hist_lo_reg);
                    span_reg <= smooth_reg - hist_lo_reg;
                    if (smooth_reg > hist_lo_reg)
                    begin
                        state_reg <= ST_COL_DIV;
                    end
                    else
                    begin
                        bar_h_reg <= '0;
                        state_reg <= ST_COL_OUT;
                    end
                end
                ST_COL_DIV:
                begin
                    state_reg <= ST_COL_WAIT;
                end
                ST_COL_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quotient > DIV_NW'(height_cfg_reg))
                        begin
                            bar_h_reg <= height_cfg_reg;
                        end
                        else
                        begin
                            bar_h_reg <= div_rsp.quotient[HEIGHT_W-1:0];
                        end
                        state_reg <= ST_COL_OUT;
                    end
                end
                ST_COL_OUT:
                begin
                    // Hold the column until the output slot is free
                    if (out_free)
                    begin
                        out_col_reg    <= COL_W'(idx_reg);
                        out_height_reg <= bar_h_reg;
                        out_top_reg    <= top_next;
                        out_last_reg   <= (idx_reg == last_addr);
                        if (idx_reg == last_addr)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= ST_COL_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_top_reg, out_height_reg, out_col_reg};

`ifndef SYNTHESIS
    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_WR) |-> (mem_waddr != mem_raddr))
        else $error("history shift reads the entry it writes");

    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COL_RD || state_reg == ST_COL_MUL || state_reg == ST_COL_OUT)
        |-> !mem_we)
        else $error("history written while columns are emitted");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COL_OUT))
        else $error("result loaded outside the column output step");
`endif

endmodule

`default_nettype wire
